// ===== hdl/kls_pkg.sv =====
// Shared constants for the k-th largest stream tracker.
// No dependencies; used by the top level.
package kls_pkg;

  // Width of the rank register as seen on the configuration port.
  localparam int unsigned KSEL_BITS = 5;

  // Rank after reset: report the largest value seen.
  localparam logic [KSEL_BITS-1:0] KSEL_RESET = KSEL_BITS'(1);

endpackage

// ===== hdl/kls_insert.sv =====
// Sorted-insert unit: places one sample into the descending top-k store.
// Purely combinational. Depends on nothing but its parameters.
module kls_insert #(
  parameter int unsigned MAX_RANK   = 16,
  parameter int unsigned VALUE_BITS = 32,
  localparam int unsigned CNT_W     = $clog2(MAX_RANK + 1),
  localparam int unsigned IDX_W     = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1
) (
  input  logic signed [VALUE_BITS-1:0] kept [MAX_RANK],
  input  logic        [CNT_W-1:0]      count,
  input  logic        [CNT_W-1:0]      keff,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic signed [VALUE_BITS-1:0] kept_next [MAX_RANK],
  output logic        [CNT_W-1:0]      count_next,
  output logic signed [VALUE_BITS-1:0] kth_value,
  output logic                         rank_reached
);

  logic [MAX_RANK-1:0] ge;
  logic [CNT_W:0]      grown;
  logic [CNT_W-1:0]    last;

  // The store is sorted largest first, so the held entries that are at least
  // as large as the sample form a prefix. An equal sample goes below them.
  always_comb begin
    for (int i = 0; i < MAX_RANK; i++) begin
      ge[i] = (CNT_W'(i) < count) && (kept[i] >= value);
    end
  end

  // Each slot keeps its entry, takes the sample, or takes its upper neighbor.
  always_comb begin
    kept_next[0] = ge[0] ? kept[0] : value;
    for (int i = 1; i < MAX_RANK; i++) begin
      if (ge[i]) begin
        kept_next[i] = kept[i];
      end else if (ge[i-1]) begin
        kept_next[i] = value;
      end else begin
        kept_next[i] = kept[i-1];
      end
    end
  end

  always_comb begin
    grown = {1'b0, count} + (CNT_W+1)'(1);
    if (grown > {1'b0, keff}) begin
      count_next = keff;
    end else begin
      count_next = grown[CNT_W-1:0];
    end
    last         = count_next - CNT_W'(1);
    kth_value    = kept_next[last[IDX_W-1:0]];
    rank_reached = (count_next == keff);
  end

endmodule

// ===== hdl/kth_largest_stream_tracker.sv =====
// Top level of the streaming k-th largest tracker.
// Depends on kls_pkg and on the sorted-insert unit kls_insert.

// The tracker keeps the k largest signed samples seen since reset in a store
// sorted from largest to smallest, and for every sample request it returns
// one result request: the smallest value still held and a flag that says
// whether at least k samples have been seen, in which case that value is the
// k-th largest. The rank k is written through the configuration port, by
// the user only while the block is idle; the block does not enforce it. Zero
// is taken as 1 and values above MAX_RANK as MAX_RANK. Lowering k trims
// the store to the new k at the next sample; raising it lets the store
// grow again from what it holds, without the values already dropped. Equal
// samples are kept as separate entries. Timing: a sample is captured in an
// input register; once the result register is free, MAX_RANK parallel
// compares and a shift-insert update the store and load the result. A new
// sample is taken every cycle unless the output stalls. The store update
// is the only loop: one compare of VALUE_BITS bits plus a two-level select
// per entry, followed by the MAX_RANK-to-1 select of the reported entry.
// The sample channel stalls only while both the input register and the
// result register are full and the result channel is stalled. The
// configuration port is always ready, and the store needs no clearing pass
// after reset.
module kth_largest_stream_tracker #(
  parameter int unsigned MAX_RANK   = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write channel for the rank k.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [kls_pkg::KSEL_BITS-1:0]        k_select,
  // Sample channel.
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic signed [VALUE_BITS-1:0]         value,
  // Result channel.
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [VALUE_BITS-1:0]         kth_value,
  output logic                                 rank_reached
);

  localparam int unsigned CNT_W = $clog2(MAX_RANK + 1);

  // Rank register and the store with its fill count. Store entries at or
  // above held_count are never read, so the store itself has no reset.
  logic [kls_pkg::KSEL_BITS-1:0] rank_k;
  logic [CNT_W-1:0]              held_count;
  logic signed [VALUE_BITS-1:0]  kept [MAX_RANK];

  // Input register.
  logic                          in_full;
  logic signed [VALUE_BITS-1:0]  in_value;

  // Insert unit outputs.
  logic signed [VALUE_BITS-1:0]  kept_next [MAX_RANK];
  logic [CNT_W-1:0]              count_next;
  logic signed [VALUE_BITS-1:0]  kth_next;
  logic                          reached_next;

  logic [CNT_W-1:0]              keff;
  logic                          out_open;
  logic                          advance;

  assign cfg_ready = 1'b1;

  // The rank register is clamped into 1..MAX_RANK before use.
  always_comb begin
    if (rank_k == '0) begin
      keff = CNT_W'(1);
    end else if (int'(rank_k) > int'(MAX_RANK)) begin
      keff = CNT_W'(MAX_RANK);
    end else begin
      keff = CNT_W'(rank_k);
    end
  end

  // The item in the input register moves on whenever the result register is
  // empty or is being emptied in this cycle.
  assign out_open     = !result_valid || !result_stall;
  assign advance      = in_full && out_open;
  assign sample_stall = in_full && !out_open;

  kls_insert #(
    .MAX_RANK   (MAX_RANK),
    .VALUE_BITS (VALUE_BITS)
  ) u_insert (
    .kept         (kept),
    .count        (held_count),
    .keff         (keff),
    .value        (in_value),
    .kept_next    (kept_next),
    .count_next   (count_next),
    .kth_value    (kth_next),
    .rank_reached (reached_next)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      rank_k       <= kls_pkg::KSEL_RESET;
      held_count   <= '0;
      in_full      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        rank_k <= k_select;
      end
      if (advance) begin
        held_count <= count_next;
      end
      if (sample_valid && !sample_stall) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      in_value <= value;
    end
    if (advance) begin
      kept         <= kept_next;
      kth_value    <= kth_next;
      rank_reached <= reached_next;
    end
  end

endmodule

// ===== hdl/kls_checker.sv =====
// Port-level checker for the k-th largest stream tracker, and its bind.
// Needs no package; sees only the top level's handshake and result ports.
module kls_checker #(
  parameter int unsigned VALUE_BITS = 32
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          sample_valid,
  input logic                          sample_stall,
  input logic                          result_valid,
  input logic                          result_stall,
  input logic signed [VALUE_BITS-1:0]  kth_value,
  input logic                          rank_reached
);

  // A result that is stalled stays offered.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result request dropped while stalled");

  // A stalled result does not change.
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(kth_value) && $stable(rank_reached))
    else $error("stalled result changed");

  // Samples are held back only by a full and stalled result side.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid && result_stall)
    else $error("sample stalled without back-pressure");

  // An accepted sample reaches the result register, after the input register,
  // when the result side is free to move in between.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) ##1 !result_stall |=> result_valid)
    else $error("sample request produced no result");

endmodule

bind kth_largest_stream_tracker kls_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_kls_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .kth_value    (kth_value),
  .rank_reached (rank_reached)
);
